[design/scanline_polygon_crossings_macros.svh]
// Assertion helpers for the port checker file.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef SCANLINE_POLYGON_CROSSINGS_MACROS_SVH
`define SCANLINE_POLYGON_CROSSINGS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spc_pkg.sv]
`default_nettype none

package spc_pkg;

  // Field widths
  localparam int COORD_BITS   = 32;
  localparam int EPS_BITS     = 16;
  localparam int DENSITY_BITS = 32;
  localparam int REGION_BITS  = 16;

  // Datapath widths: nudged compare coordinates carry one extra bit,
  // differences of those two extra bits, products sum to 2*C+3 bits.
  localparam int DIFF_BITS = COORD_BITS + 2;
  localparam int NUM_BITS  = 2 * COORD_BITS + 3;
  localparam int QUO_BITS  = COORD_BITS + 1;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_MODE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_EPSILON   = CFG_INDEX_BITS'(1);

  // Request codes
  localparam logic REQ_PRIME  = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                    req_type;
    coord_t                  vertex_x;
    coord_t                  vertex_y;
    coord_t                  ray_level;
    logic [DENSITY_BITS-1:0] region_density;
    logic [REGION_BITS-1:0]  region_id;
  } in_t;

  typedef struct packed {
    coord_t                  crossing_coord;
    logic [DENSITY_BITS-1:0] crossing_density;
    logic [REGION_BITS-1:0]  crossing_region;
  } out_t;

  // Main sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SETUP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Serial divider
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RANGE,
    DV_STEP,
    DV_SAT
  } div_state_t;

endpackage

`default_nettype wire

[design/spc_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Signed numerator / signed denominator, truncated toward zero and
// saturated to the signed coordinate range. Denominator must be nonzero.
module spc_divider (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [spc_pkg::NUM_BITS-1:0]   num,
  input  wire logic signed [spc_pkg::DIFF_BITS-1:0]  den,
  output logic                                       done,
  output spc_pkg::coord_t                            quo
);
  import spc_pkg::*;

  localparam int HI_BITS  = NUM_BITS - QUO_BITS;
  localparam int CNT_BITS = $clog2(QUO_BITS);

  div_state_t state, state_next;

  logic                 neg;
  logic                 sat;
  logic [NUM_BITS-1:0]  mag;
  logic [DIFF_BITS-1:0] dmag;
  logic [DIFF_BITS-1:0] rem;
  logic [QUO_BITS-1:0]  qsh;
  logic [CNT_BITS-1:0]  cnt;

  logic [HI_BITS-1:0]   mag_hi;
  logic                 range_ovf;
  logic [DIFF_BITS:0]   trial;
  logic                 take;
  logic [QUO_BITS-1:0]  limit;
  logic [QUO_BITS-1:0]  q_clip;
  logic [QUO_BITS-1:0]  q_signed;

  // Upper numerator bits must stay below the divisor for the quotient to fit
  assign mag_hi    = mag[NUM_BITS-1 -: HI_BITS];
  assign range_ovf = ({{(DIFF_BITS-HI_BITS+1){1'b0}}, mag_hi} >= {1'b0, dmag});

  // One restoring step
  assign trial = {rem, qsh[QUO_BITS-1]};
  assign take  = (trial >= {1'b0, dmag});

  // Saturation bound: 2^(C-1) for negative results, 2^(C-1)-1 otherwise
  assign limit    = (QUO_BITS'(1) << (COORD_BITS - 1)) - QUO_BITS'(!neg);
  assign q_clip   = (sat || (qsh > limit)) ? limit : qsh;
  assign q_signed = neg ? (QUO_BITS'(0) - q_clip) : q_clip;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          state_next = DV_RANGE;
        end
      end
      DV_RANGE: begin
        state_next = range_ovf ? DV_SAT : DV_STEP;
      end
      DV_STEP: begin
        if (cnt == '0) begin
          state_next = DV_SAT;
        end
      end
      DV_SAT: begin
        state_next = DV_IDLE;
      end
      default: begin
        state_next = DV_IDLE;
      end
    endcase
  end

  // Done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == DV_SAT);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          neg  <= num[NUM_BITS-1] ^ den[DIFF_BITS-1];
          mag  <= num[NUM_BITS-1] ? (NUM_BITS'(0) - num) : num;
          dmag <= den[DIFF_BITS-1] ? (DIFF_BITS'(0) - den) : den;
        end
      end
      DV_RANGE: begin
        sat <= range_ovf;
        rem <= mag_hi;
        qsh <= mag[QUO_BITS-1:0];
        cnt <= CNT_BITS'(QUO_BITS - 1);
      end
      DV_STEP: begin
        // remainder stays below the divisor, so it fits DIFF_BITS
        rem <= take ? DIFF_BITS'(trial - {1'b0, dmag}) : trial[DIFF_BITS-1:0];
        qsh <= {qsh[QUO_BITS-2:0], take};
        cnt <= cnt - CNT_BITS'(1);
      end
      DV_SAT: begin
        quo <= q_signed[COORD_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/scanline_polygon_crossings.sv]
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  in_data  (spc_pkg::in_t)
// out       out  out_valid/ out_stall out_data (spc_pkg::out_t)
// cfg       in   cfg_wr_en            cfg_index, cfg_wr_data
//
// One beat is worked on at a time. A prime beat only loads the previous
// vertex; a vertex whose edge misses the ray is dropped after the test; a
// zero denominator after the nudge goes straight to output; a crossing runs
// a bit-serial shift-add multiply over COORD_BITS+2 multiplier bits, then a
// restoring divide of COORD_BITS+1 steps; an out-of-range quotient skips them.
// Reset (rst, synchronous) sets axis_mode=1, epsilon=1, previous vertex 0.
// A result waits in the output register under out_stall; the next input
// beat is taken meanwhile, and only the final write of a later result waits.
module scanline_polygon_crossings (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire spc_pkg::in_t                           in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output spc_pkg::out_t                               out_data,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [spc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data
);
  import spc_pkg::*;

  localparam int MCNT_BITS = $clog2(DIFF_BITS);
  localparam int WIDE_BITS = COORD_BITS + 1;

  state_t state, state_next;

  // Configuration
  logic                axis_mode;
  logic [EPS_BITS-1:0] epsilon;

  // Previous vertex
  coord_t prev_x;
  coord_t prev_y;

  // Edge under test
  coord_t                        a_out;
  coord_t                        b_out;
  logic signed [WIDE_BITS-1:0]   a_cmp;
  logic signed [WIDE_BITS-1:0]   b_cmp;
  logic signed [WIDE_BITS-1:0]   ray;
  logic [DENSITY_BITS-1:0]       dens;
  logic [REGION_BITS-1:0]        region;

  // Serial multiply
  logic signed [NUM_BITS-1:0]    mcand_a;
  logic signed [NUM_BITS-1:0]    mcand_b;
  logic signed [DIFF_BITS-1:0]   mplier_a;
  logic signed [DIFF_BITS-1:0]   mplier_b;
  logic signed [NUM_BITS-1:0]    acc;
  logic [MCNT_BITS-1:0]          mul_cnt;
  logic signed [DIFF_BITS-1:0]   den;
  coord_t                        res;

  // Control strobes
  logic   in_fire;
  logic   div_start;
  logic   out_load;
  logic   div_done;
  coord_t div_quo;

  logic                          crosses;
  logic signed [WIDE_BITS-1:0]   eps_ext;
  logic signed [DIFF_BITS-1:0]   a_ext;
  logic signed [DIFF_BITS-1:0]   b_ext;
  logic signed [DIFF_BITS-1:0]   r_ext;
  logic signed [NUM_BITS-1:0]    term_a;
  logic signed [NUM_BITS-1:0]    term_b;

  assign in_fire = in_valid && !in_stall;

  // Edge straddles the ray and is not flat
  assign crosses = (((a_cmp <= ray) && (b_cmp >= ray)) ||
                    ((a_cmp >= ray) && (b_cmp <= ray))) && (a_cmp != b_cmp);

  assign eps_ext = $signed({{(WIDE_BITS-EPS_BITS){1'b0}}, epsilon});
  assign a_ext   = $signed({a_cmp[WIDE_BITS-1], a_cmp});
  assign b_ext   = $signed({b_cmp[WIDE_BITS-1], b_cmp});
  assign r_ext   = $signed({ray[WIDE_BITS-1], ray});

  // Partial products for the current multiplier bits
  assign term_a = mplier_a[0] ? mcand_a : '0;
  assign term_b = mplier_b[0] ? mcand_b : '0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode <= 1'b1;
      epsilon   <= EPS_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_AXIS_MODE: axis_mode <= cfg_wr_data[0];
        REG_EPSILON:   epsilon   <= cfg_wr_data[EPS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.req_type == REQ_VERTEX)) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        state_next = crosses ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        state_next = (a_cmp == b_cmp) ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt == '0) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Previous vertex follows every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (in_fire) begin
      prev_x <= in_data.vertex_x;
      prev_y <= in_data.vertex_y;
    end
  end

  // Edge datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          ray    <= $signed({in_data.ray_level[COORD_BITS-1], in_data.ray_level});
          dens   <= in_data.region_density;
          region <= in_data.region_id;
          if (axis_mode) begin
            a_out <= in_data.vertex_x;
            b_out <= prev_x;
            a_cmp <= $signed({in_data.vertex_y[COORD_BITS-1], in_data.vertex_y});
            b_cmp <= $signed({prev_y[COORD_BITS-1], prev_y});
          end else begin
            a_out <= in_data.vertex_y;
            b_out <= prev_y;
            a_cmp <= $signed({in_data.vertex_x[COORD_BITS-1], in_data.vertex_x});
            b_cmp <= $signed({prev_x[COORD_BITS-1], prev_x});
          end
        end
      end
      ST_TEST: begin
        // nudge an endpoint sitting on the ray, current one first
        if (a_cmp == ray) begin
          a_cmp <= a_cmp + eps_ext;
        end else if (b_cmp == ray) begin
          b_cmp <= b_cmp + eps_ext;
        end
      end
      ST_SETUP: begin
        res      <= a_out;
        mplier_a <= b_ext - r_ext;
        mplier_b <= r_ext - a_ext;
        den      <= b_ext - a_ext;
        mcand_a  <= $signed({{(NUM_BITS-COORD_BITS){a_out[COORD_BITS-1]}}, a_out});
        mcand_b  <= $signed({{(NUM_BITS-COORD_BITS){b_out[COORD_BITS-1]}}, b_out});
        acc      <= '0;
        mul_cnt  <= MCNT_BITS'(DIFF_BITS - 1);
      end
      ST_MUL: begin
        // multiplier sign bit carries negative weight
        if (mul_cnt == '0) begin
          acc <= acc - term_a - term_b;
        end else begin
          acc <= acc + term_a + term_b;
        end
        mcand_a  <= mcand_a <<< 1;
        mcand_b  <= mcand_b <<< 1;
        mplier_a <= mplier_a >>> 1;
        mplier_b <= mplier_b >>> 1;
        mul_cnt  <= mul_cnt - MCNT_BITS'(1);
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res <= div_quo;
        end
      end
      default: begin
      end
    endcase
  end

  // Quotient unit
  spc_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.crossing_coord   <= res;
      out_data.crossing_density <= dens;
      out_data.crossing_region  <= region;
    end
  end

endmodule

`default_nettype wire

[design/spc_checker.sv]
`default_nettype none

`include "scanline_polygon_crossings_macros.svh"

// Port-level checks for the crossing unit.
module spc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire spc_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire spc_pkg::out_t out_data
);
  import spc_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // A stalled result holds
  `SPC_ASSERT_NEXT(out_hold_chk, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A vertex beat starts work, so the input stalls next cycle
  `SPC_ASSERT_NEXT(vertex_busy_chk, in_beat && (in_data.req_type == REQ_VERTEX), in_stall, "vertex beat did not occupy the unit")

  // A prime beat only loads the previous vertex
  `SPC_ASSERT_NEXT(prime_free_chk, in_beat && (in_data.req_type == REQ_PRIME), !in_stall, "prime beat left the unit busy")

  // A new result appears only as work finishes
  `SPC_ASSERT_NOW(result_src_chk, $rose(out_valid), $past(in_stall) && !in_stall, "result appeared outside the finish step")

endmodule

bind scanline_polygon_crossings spc_checker u_spc_checker (.*);

`default_nettype wire

[sim/scanline_polygon_crossings_checker.sv]
`timescale 1ns / 100ps

// Watches the vertex, crossing and register ports of the crossing unit.
// Keeps its own copy of the previous vertex and the registers, works out
// the crossing for every accepted vertex beat and compares the results.
module scanline_polygon_crossings_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_stall,
  input  wire spc_pkg::in_t                           in_data,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_stall,
  input  wire spc_pkg::out_t                          out_data,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [spc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data,
  output int unsigned                                 fail_count,
  output int unsigned                                 pending,
  output int unsigned                                 compared
);

  localparam int MAX_PRINTS = 40;
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (spc_pkg::COORD_BITS - 1)) - 1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (spc_pkg::COORD_BITS - 1));

  // Shadow registers and previous vertex
  logic                          axis_mode_q;
  logic [spc_pkg::EPS_BITS-1:0]  eps_q;
  spc_pkg::coord_t               prev_x_q;
  spc_pkg::coord_t               prev_y_q;

  spc_pkg::out_t crossings_q[$];
  int unsigned   compared_n;

  initial begin
    fail_count = 0;
    pending    = 0;
    compared   = 0;
    compared_n = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Edge (current, previous) against the ray; 1 when it crosses.
  function automatic logic predict_crossing(input spc_pkg::in_t beat,
                                            output spc_pkg::out_t res);
    logic signed [127:0] a_out, a_cmp, b_out, b_cmp, ray, den, num, quo;
    res   = '0;
    ray   = $signed(beat.ray_level);
    if (axis_mode_q) begin
      a_out = $signed(beat.vertex_x);
      a_cmp = $signed(beat.vertex_y);
      b_out = $signed(prev_x_q);
      b_cmp = $signed(prev_y_q);
    end else begin
      a_out = $signed(beat.vertex_y);
      a_cmp = $signed(beat.vertex_x);
      b_out = $signed(prev_y_q);
      b_cmp = $signed(prev_x_q);
    end
    if (a_cmp == b_cmp)
      return 1'b0;
    if (!((a_cmp <= ray && b_cmp >= ray) || (a_cmp >= ray && b_cmp <= ray)))
      return 1'b0;
    // endpoint on the ray: nudge current first, else previous, at full width
    if (a_cmp == ray)
      a_cmp = a_cmp + $signed({112'd0, eps_q});
    else if (b_cmp == ray)
      b_cmp = b_cmp + $signed({112'd0, eps_q});
    den = b_cmp - a_cmp;
    if (den == 0) begin
      quo = a_out;
    end else begin
      num = a_out * (b_cmp - ray) + b_out * (ray - a_cmp);
      quo = num / den;
      if (quo > SAT_HI)
        quo = SAT_HI;
      else if (quo < SAT_LO)
        quo = SAT_LO;
    end
    res.crossing_coord   = spc_pkg::coord_t'(quo[spc_pkg::COORD_BITS-1:0]);
    res.crossing_density = beat.region_density;
    res.crossing_region  = beat.region_id;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    spc_pkg::out_t want;
    spc_pkg::out_t crossing;
    logic          hit;
    if (rst) begin
      axis_mode_q = 1'b1;
      eps_q       = spc_pkg::EPS_BITS'(1);
      prev_x_q    = '0;
      prev_y_q    = '0;
      crossings_q.delete();
    end else begin
      // result beat against the oldest expectation (before any new push)
      if (out_valid && !out_stall) begin
        if (crossings_q.size() == 0) begin
          report_mismatch("unexpected crossing beat", 64'(out_data.crossing_coord), 64'd0);
        end else begin
          want = crossings_q.pop_front();
          compared_n++;
          if (out_data.crossing_coord !== want.crossing_coord)
            report_mismatch("crossing_coord", 64'(out_data.crossing_coord),
                            64'(want.crossing_coord));
          if (out_data.crossing_density !== want.crossing_density)
            report_mismatch("crossing_density", 64'(out_data.crossing_density),
                            64'(want.crossing_density));
          if (out_data.crossing_region !== want.crossing_region)
            report_mismatch("crossing_region", 64'(out_data.crossing_region),
                            64'(want.crossing_region));
        end
      end
      // accepted beat: predict if it is a vertex, then remember it as the previous vertex
      if (in_valid && !in_stall) begin
        if (in_data.req_type == spc_pkg::REQ_VERTEX) begin
          hit = predict_crossing(in_data, crossing);
          if (hit)
            crossings_q = {crossings_q, crossing};
        end
        prev_x_q = in_data.vertex_x;
        prev_y_q = in_data.vertex_y;
      end
      // register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        if (cfg_index == spc_pkg::REG_AXIS_MODE)
          axis_mode_q = cfg_wr_data[0];
        else if (cfg_index == spc_pkg::REG_EPSILON)
          eps_q = cfg_wr_data[spc_pkg::EPS_BITS-1:0];
      end
    end
    pending  <= crossings_q.size();
    compared <= compared_n;
  end

endmodule

[sim/scanline_polygon_crossings_tb.sv]
`timescale 1ns / 100ps

module scanline_polygon_crossings_tb;

  localparam int               DRAIN_CYCLES = 2 * spc_pkg::COORD_BITS + 30;
  localparam int               IDLE_GUARD   = 5000;
  localparam int               PHASE_BEATS  = 150;
  localparam spc_pkg::coord_t  C_MAX = 32'sh7FFF_FFFF;
  localparam spc_pkg::coord_t  C_MIN = 32'sh8000_0000;
  localparam spc_pkg::coord_t  ONE   = 32'sh0001_0000;

  logic                                 clk;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  spc_pkg::in_t                         in_data = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  spc_pkg::out_t                        out_data;
  logic                                 cfg_wr_en = 1'b0;
  logic [spc_pkg::CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [spc_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data = '0;

  int unsigned fail_count, pending, compared;

  // stimulus bookkeeping
  logic                          calm = 1'b0;
  logic [spc_pkg::EPS_BITS-1:0]  cur_eps = 1;
  int unsigned                   beats_sent = 0;
  int unsigned                   phase_beats = 0;
  int unsigned                   settings_run = 1;

  scanline_polygon_crossings i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  scanline_polygon_crossings_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic spc_pkg::in_t mk_beat(input logic req, input spc_pkg::coord_t x,
                                           input spc_pkg::coord_t y,
                                           input spc_pkg::coord_t ray,
                                           input logic [31:0] dens, input logic [15:0] id);
    spc_pkg::in_t b;
    b.req_type       = req;
    b.vertex_x       = x;
    b.vertex_y       = y;
    b.ray_level      = ray;
    b.region_density = dens;
    b.region_id      = id;
    return b;
  endfunction

  // coordinates biased toward the ray, its nudged position and the extremes
  function automatic spc_pkg::coord_t rand_coord(input spc_pkg::coord_t ray);
    case ($urandom_range(0, 11))
      0, 1:    return spc_pkg::coord_t'($urandom);
      2:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      3:       return ray;
      4:       return spc_pkg::coord_t'(ray + 32'(cur_eps));
      5:       return spc_pkg::coord_t'(ray - 32'($urandom_range(0, 3)));
      6:       return spc_pkg::coord_t'(ray + 32'(cur_eps) + 32'($urandom_range(0, 3)));
      default: return spc_pkg::coord_t'(32'($urandom_range(0, 24'hFF_FFFF)) - 32'h80_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_density();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_region();
    case ($urandom_range(0, 7))
      0:       return 16'h0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input beat, after a random gap; valid stays up across back-to-back beats
  task automatic send_beat(input spc_pkg::in_t b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    phase_beats++;
  endtask

  task automatic write_reg(input logic [spc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [spc_pkg::CFG_DATA_BITS-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == spc_pkg::REG_EPSILON)
      cur_eps = data;
  endtask

  // wait until every predicted crossing is back, then let a miss finish
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < IDLE_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a polygon: prime with its last vertex (unless broken), then every vertex
  task automatic send_polygon(input logic with_prime);
    spc_pkg::coord_t vx[8];
    spc_pkg::coord_t vy[8];
    spc_pkg::coord_t ray;
    int unsigned     n;
    case ($urandom_range(0, 5))
      0:       ray = spc_pkg::coord_t'($urandom);
      1:       ray = $urandom_range(0, 1) ? C_MAX : C_MIN;
      default: ray = spc_pkg::coord_t'(32'($urandom_range(0, 24'hFF_FFFF)) - 32'h80_0000);
    endcase
    n = $urandom_range(3, 8);
    for (int i = 0; i < n; i++) begin
      vx[i] = rand_coord(ray);
      vy[i] = rand_coord(ray);
    end
    if (with_prime)
      send_beat(mk_beat(spc_pkg::REQ_PRIME, vx[n-1], vy[n-1], ray,
                        rand_density(), rand_region()));
    for (int i = 0; i < n; i++)
      send_beat(mk_beat(spc_pkg::REQ_VERTEX, vx[i], vy[i], ray,
                        rand_density(), rand_region()));
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_beat(mk_beat(1'($urandom_range(0, 1)), spc_pkg::coord_t'($urandom),
                        spc_pkg::coord_t'($urandom), spc_pkg::coord_t'($urandom),
                        $urandom, 16'($urandom)));
  endtask

  // receiver side: random stall before each result beat
  initial begin : result_side
    int unsigned hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic                         axis_sel;
    logic [spc_pkg::EPS_BITS-1:0] eps_sel;
    int unsigned                  pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset registers (horizontal rays, epsilon 1)
    // vertex before any prime uses the reset previous vertex
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 3 * ONE, 2 * ONE, ONE, 32'h1234_5678, 16'h0042));
    send_beat(mk_beat(spc_pkg::REQ_PRIME, C_MAX, C_MIN, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, C_MIN, C_MAX, 0, 32'hFFFF_FFFF, 16'hFFFF));
    // horizontal edge lying on the ray
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 0, C_MAX, C_MAX, 32'h1, 16'h1));
    // current endpoint on the ray
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 0, 5 * ONE, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 2 * ONE, ONE, ONE, 32'h0, 16'h0));
    // previous endpoint on the ray
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 4 * ONE, 3 * ONE, ONE, 32'hDEAD_BEEF, 16'h7));
    // nudge makes the denominator zero
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 7 * ONE, ONE + 1, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 9 * ONE, ONE, ONE, 32'h5, 16'h9));
    // quotient beyond both bounds
    send_beat(mk_beat(spc_pkg::REQ_PRIME, C_MAX, ONE + 2, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, C_MIN, ONE, ONE, 32'h8000_0000, 16'h8000));
    send_beat(mk_beat(spc_pkg::REQ_PRIME, C_MIN, ONE + 2, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, C_MAX, ONE, ONE, 32'h7FFF_FFFF, 16'h7FFF));
    // edge that misses the ray
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 0, 0, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, ONE, 5 * ONE, -3 * ONE, 32'h3, 16'h3));
    // ray at the lowest level, endpoint on it
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, ONE, C_MIN, C_MIN, 32'h0, 16'h0));
    wait_idle();

    // directed, swapped axes and the widest nudge
    write_reg(spc_pkg::REG_EPSILON, 16'hFFFF);
    write_reg(spc_pkg::REG_AXIS_MODE, 16'h0);
    // nudged compare coordinate past the coordinate range
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 0, 3 * ONE, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, C_MAX, ONE, C_MAX, 32'hFFFF_FFFF, 16'hFFFF));
    // zero denominator after nudge
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 5 * ONE + 32'hFFFF, 2 * ONE, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 5 * ONE, 5 * ONE, 5 * ONE, 32'h11, 16'h22));
    // edge parallel to the ray
    send_beat(mk_beat(spc_pkg::REQ_PRIME, 5 * ONE, ONE, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 5 * ONE, 9 * ONE, 5 * ONE, 32'h0, 16'h0));
    wait_idle();

    // writes past the register list must leave the settings alone
    write_reg(spc_pkg::CFG_INDEX_BITS'(2), 16'hFFFF);
    write_reg(spc_pkg::CFG_INDEX_BITS'(3), 16'h0001);
    send_beat(mk_beat(spc_pkg::REQ_PRIME, -4 * ONE, 0, 0, 32'h0, 16'h0));
    send_beat(mk_beat(spc_pkg::REQ_VERTEX, 4 * ONE, 8 * ONE, 0, 32'hCAFE_0001, 16'h00AA));
    wait_idle();
    settings_run = 2;

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin axis_sel = 1'b1; eps_sel = 16'h0;    end
        1:       begin axis_sel = 1'b0; eps_sel = 16'h1;    end
        2:       begin axis_sel = 1'b1; eps_sel = 16'hFFFF; end
        3:       begin axis_sel = 1'b0; eps_sel = 16'h0;    end
        default: begin axis_sel = 1'(ph); eps_sel = 16'($urandom); end
      endcase
      write_reg(spc_pkg::REG_AXIS_MODE, {15'd0, axis_sel});
      write_reg(spc_pkg::REG_EPSILON, eps_sel);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        calm <= ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7)
          send_polygon(1'b1);
        else if (pick == 7)
          send_polygon(1'b0);
        else
          send_noise();
      end
      wait_idle();
      settings_run++;
    end

    $display("Sent %0d vertex and prime beats across %0d register settings.",
             beats_sent, settings_run);
    $display("Compared %0d crossing beats, %0d mismatches.", compared, fail_count);
    if (pending != 0)
      $display("%0d predicted crossings never arrived.", pending);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[scanline_polygon_crossings.f]
+incdir+design
design/spc_pkg.sv
design/spc_divider.sv
design/scanline_polygon_crossings.sv
design/spc_checker.sv
sim/scanline_polygon_crossings_checker.sv
sim/scanline_polygon_crossings_tb.sv
